### hw/rtl/ffp_pkg.sv
// package for the format flag parser
// character codes, item classes and the queue entry that front and back share
// no dependencies

package ffp_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_STAR  = 8'h2a;

	localparam logic [30:0] ACC_MAX   = 31'h7fff_ffff;
	localparam logic [31:0] PREC_NONE = 32'hffff_ffff;
	localparam logic [31:0] ARG_MIN   = 32'h8000_0000;

	typedef enum logic [3:0] {
		CL_MINUS,
		CL_ZERO,
		CL_DIGIT,
		CL_HASH,
		CL_PLUS,
		CL_SPACE,
		CL_DOT,
		CL_STAR,
		CL_END
	} ffp_cls_t;

	typedef struct packed {
		logic               start;
		ffp_cls_t           cls;
		logic [3:0]         digit;
		logic signed [31:0] arg;
	} ffp_entry_t;

endpackage

### hw/rtl/ffp_front.sv
// front end of the format flag parser: classifies each input beat
// and pushes it into the queue; depends on ffp_pkg

module ffp_front (
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               start_req,
	input  logic [7:0]         ch,
	input  logic signed [31:0] arg_value,
	input  logic               q_full,
	output logic               q_push,
	output ffp_pkg::ffp_entry_t q_entry
);
	import ffp_pkg::*;

	ffp_cls_t cls;

	always_comb begin
		case (ch) inside
			CH_MINUS:           cls = CL_MINUS;
			CH_ZERO:            cls = CL_ZERO;
			[CH_ONE:CH_NINE]:   cls = CL_DIGIT;
			CH_HASH:            cls = CL_HASH;
			CH_PLUS:            cls = CL_PLUS;
			CH_SPACE:           cls = CL_SPACE;
			CH_DOT:             cls = CL_DOT;
			CH_STAR:            cls = CL_STAR;
			default:            cls = CL_END;
		endcase
	end

	assign in_stall        = q_full;
	assign q_push          = in_valid && !q_full;
	assign q_entry.start   = start_req;
	assign q_entry.cls     = cls;
	assign q_entry.digit   = ch[3:0];
	assign q_entry.arg     = arg_value;

endmodule

### hw/rtl/ffp_queue.sv
// short queue between front and back of the format flag parser
// depends on ffp_pkg for the entry type

module ffp_queue #(
	parameter int unsigned DEPTH = ffp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ffp_pkg::ffp_entry_t wr_entry,
	output logic                full,
	input  logic                pop,
	output ffp_pkg::ffp_entry_t rd_entry,
	output logic                empty
);
	import ffp_pkg::*;

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	ffp_entry_t    mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("push lost");
`endif

endmodule

### hw/rtl/ffp_back.sv
// back end of the format flag parser: applies each queued beat to the
// flag, width and precision state and registers the result; depends on ffp_pkg

module ffp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  ffp_pkg::ffp_entry_t q_entry,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                done_res,
	output logic                left_justify,
	output logic                zero_pad,
	output logic                alt_form,
	output logic                show_plus,
	output logic                show_space,
	output logic [30:0]         field_width,
	output logic signed [31:0]  field_precision
);
	import ffp_pkg::*;

	// parser state
	logic        minus_q, zero_q, hash_q, plus_q, space_q, dot_q;
	logic [30:0] width_q;
	logic [31:0] prec_q;

	// result register
	logic        out_valid_q;
	logic        done_q, o_minus_q, o_zero_q, o_hash_q, o_plus_q, o_space_q;
	logic [30:0] o_width_q;
	logic [31:0] o_prec_q;

	// state after an optional start clear
	logic        b_minus, b_zero, b_hash, b_plus, b_space, b_dot;
	logic [30:0] b_width;
	logic [31:0] b_prec;

	logic        n_minus, n_zero, n_hash, n_plus, n_space, n_dot, n_done;
	logic [30:0] n_width;
	logic [31:0] n_prec;

	logic        mac_prec;
	logic [30:0] mac_in;
	logic [34:0] mac_sum;
	logic [30:0] mac_out;
	logic [31:0] star_prec;
	logic [30:0] star_width;
	logic        handled;

	assign q_pop = !q_empty && (!out_valid_q || !out_stall);

	always_comb begin
		b_minus = q_entry.start ? 1'b0 : minus_q;
		b_zero  = q_entry.start ? 1'b0 : zero_q;
		b_hash  = q_entry.start ? 1'b0 : hash_q;
		b_plus  = q_entry.start ? 1'b0 : plus_q;
		b_space = q_entry.start ? 1'b0 : space_q;
		b_dot   = q_entry.start ? 1'b0 : dot_q;
		b_width = q_entry.start ? '0 : width_q;
		b_prec  = q_entry.start ? PREC_NONE : prec_q;
	end

	// times ten plus digit, saturating; a set precision is never negative
	assign mac_prec = (b_prec != PREC_NONE);
	assign mac_in   = mac_prec ? b_prec[30:0] : b_width;
	assign mac_sum  = {1'b0, mac_in, 3'b000} + {3'b000, mac_in, 1'b0}
		+ {31'd0, q_entry.digit};
	assign mac_out  = (mac_sum[34:31] != 4'd0) ? ACC_MAX : mac_sum[30:0];

	assign star_prec  = q_entry.arg[31] ? PREC_NONE : q_entry.arg;
	assign star_width = (q_entry.arg == ARG_MIN) ? ACC_MAX
		: 31'(-q_entry.arg);

	always_comb begin
		n_minus = b_minus;
		n_zero  = b_zero;
		n_hash  = b_hash;
		n_plus  = b_plus;
		n_space = b_space;
		n_dot   = b_dot;
		n_width = b_width;
		n_prec  = b_prec;
		n_done  = 1'b0;
		handled = 1'b0;
		if (b_dot) begin
			if (q_entry.cls == CL_STAR) begin
				n_prec  = star_prec;
				n_dot   = 1'b0;
				handled = 1'b1;
			end else if (q_entry.cls == CL_DIGIT || q_entry.cls == CL_ZERO) begin
				n_prec  = {1'b0, mac_out};
				handled = 1'b1;
			end else begin
				n_dot = 1'b0;
			end
		end
		if (!handled) begin
			case (q_entry.cls)
				CL_MINUS: n_minus = 1'b1;
				CL_HASH:  n_hash  = 1'b1;
				CL_PLUS:  n_plus  = 1'b1;
				CL_SPACE: n_space = 1'b1;
				CL_DOT: begin
					n_zero = 1'b0;
					n_prec = '0;
					n_dot  = 1'b1;
				end
				CL_ZERO, CL_DIGIT: begin
					// zero is a flag only ahead of any width or minus
					if (q_entry.cls == CL_ZERO && b_width == '0 && !b_minus) begin
						n_zero = 1'b1;
					end else if (mac_prec) begin
						n_prec = {1'b0, mac_out};
					end else begin
						n_width = mac_out;
					end
				end
				CL_STAR: begin
					if (mac_prec) begin
						n_prec = star_prec;
					end else if (q_entry.arg[31]) begin
						n_minus = 1'b1;
						n_width = star_width;
					end else begin
						n_width = q_entry.arg[30:0];
					end
				end
				default: n_done = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			minus_q     <= 1'b0;
			zero_q      <= 1'b0;
			hash_q      <= 1'b0;
			plus_q      <= 1'b0;
			space_q     <= 1'b0;
			dot_q       <= 1'b0;
			width_q     <= '0;
			prec_q      <= PREC_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				minus_q <= n_minus;
				zero_q  <= n_zero;
				hash_q  <= n_hash;
				plus_q  <= n_plus;
				space_q <= n_space;
				dot_q   <= n_dot;
				width_q <= n_width;
				prec_q  <= n_prec;
			end
			if (q_pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			done_q    <= n_done;
			o_minus_q <= n_minus;
			o_zero_q  <= n_zero;
			o_hash_q  <= n_hash;
			o_plus_q  <= n_plus;
			o_space_q <= n_space;
			o_width_q <= n_width;
			o_prec_q  <= n_prec;
		end
	end

	assign out_valid       = out_valid_q;
	assign done_res        = done_q;
	assign left_justify    = o_minus_q;
	assign zero_pad        = o_zero_q;
	assign alt_form        = o_hash_q;
	assign show_plus       = o_plus_q;
	assign show_space      = o_space_q;
	assign field_width     = o_width_q;
	assign field_precision = o_prec_q;

`ifndef SYNTH
	a_prec_range: assert property (@(posedge clk) disable iff (!arst_n)
		prec_q[31] |-> prec_q == PREC_NONE)
		else $error("precision below minus one");
	a_dot_has_prec: assert property (@(posedge clk) disable iff (!arst_n)
		dot_q |-> !prec_q[31])
		else $error("dot run without precision");
	a_end_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_entry.cls == CL_END && !q_entry.start)
		|=> $stable(width_q) && $stable(prec_q) && !dot_q)
		else $error("end character changed state");
`endif

endmodule

### hw/rtl/format_flag_parser.sv
// top level of the format flag parser: front classifier, queue, back executor
// depends on ffp_pkg, ffp_front, ffp_queue, ffp_back
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | start_req, ch, arg_value
//   out     | output    | out_valid / out_stall| done_res, flags, width, precision
//
// one beat in per cycle, one result out per cycle, sustained while out_stall is low
// out_valid rises when a queued beat is popped into the result register
// the back end does one times-ten accumulate per popped beat; that sets the rate
// arst_n clears the flags, width 0, precision -1 and empties the queue
// out_stall backs up into the queue; in_stall rises only when the queue is full

module format_flag_parser #(
	parameter int unsigned QUEUE_DEPTH = ffp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               start_req,
	input  logic [7:0]         ch,
	input  logic signed [31:0] arg_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               done_res,
	output logic               left_justify,
	output logic               zero_pad,
	output logic               alt_form,
	output logic               show_plus,
	output logic               show_space,
	output logic [30:0]        field_width,
	output logic signed [31:0] field_precision
);
	import ffp_pkg::*;

	logic       q_push, q_pop, q_full, q_empty;
	ffp_entry_t wr_entry, rd_entry;

	ffp_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.start_req (start_req),
		.ch        (ch),
		.arg_value (arg_value),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (wr_entry)
	);

	ffp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (wr_entry),
		.full     (q_full),
		.pop      (q_pop),
		.rd_entry (rd_entry),
		.empty    (q_empty)
	);

	ffp_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.q_entry         (rd_entry),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.done_res        (done_res),
		.left_justify    (left_justify),
		.zero_pad        (zero_pad),
		.alt_form        (alt_form),
		.show_plus       (show_plus),
		.show_space      (show_space),
		.field_width     (field_width),
		.field_precision (field_precision)
	);

endmodule

### tb/testbench.sv
// self-checking bench for format_flag_parser: printf spec characters in, flag state out
// depends on ffp_pkg and the format_flag_parser rtl; predicts each result beat in place
`timescale 1ns / 1ps

module testbench;
	import ffp_pkg::*;

	typedef struct {
		logic               start;
		logic [7:0]         ch;
		logic signed [31:0] arg;
	} spec_char_t;

	typedef struct packed {
		logic               done;
		logic               minus;
		logic               zero;
		logic               hash;
		logic               plus;
		logic               space;
		logic [30:0]        width;
		logic signed [31:0] prec;
	} flag_state_t;

	localparam longint SAT_MAX = longint'(ACC_MAX);
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam string CONV_CHARS = "diouxXcspfegn%";

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               start_req = 1'b0;
	logic [7:0]         ch = '0;
	logic signed [31:0] arg_value = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               done_res;
	logic               left_justify;
	logic               zero_pad;
	logic               alt_form;
	logic               show_plus;
	logic               show_space;
	logic [30:0]        field_width;
	logic signed [31:0] field_precision;

	spec_char_t  spec_chars[$];
	flag_state_t flags_due[$];
	spec_char_t  cur_char;
	int          gap_left = 0;
	int          stall_left = 0;
	int          mismatches = 0;

	// parser state mirrored by the predictor
	logic   st_minus, st_zero, st_hash, st_plus, st_space, st_dot;
	longint st_width, st_prec;

	format_flag_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.start_req(start_req),
		.ch(ch),
		.arg_value(arg_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.done_res(done_res),
		.left_justify(left_justify),
		.zero_pad(zero_pad),
		.alt_form(alt_form),
		.show_plus(show_plus),
		.show_space(show_space),
		.field_width(field_width),
		.field_precision(field_precision)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void clear_spec();
		st_minus = 1'b0;
		st_zero  = 1'b0;
		st_hash  = 1'b0;
		st_plus  = 1'b0;
		st_space = 1'b0;
		st_dot   = 1'b0;
		st_width = 0;
		st_prec  = -1;
	endfunction

	function automatic longint times_ten_add(longint acc, logic [3:0] d);
		longint r;
		r = acc * 10 + longint'(d);
		return (r > SAT_MAX) ? SAT_MAX : r;
	endfunction

	function automatic flag_state_t parse_char(spec_char_t c);
		longint      arg;
		logic        digit;
		logic        taken;
		logic [3:0]  d;
		flag_state_t r;
		arg = c.arg;
		digit = (c.ch >= CH_ZERO) && (c.ch <= CH_NINE);
		d = 4'(c.ch - CH_ZERO);
		taken = 1'b0;
		r = '0;
		if (c.start)
			clear_spec();
		if (st_dot) begin
			if (c.ch == CH_STAR) begin
				st_prec = (arg < 0) ? -1 : arg;
				st_dot = 1'b0;
				taken = 1'b1;
			end else if (digit) begin
				st_prec = times_ten_add(st_prec, d);
				taken = 1'b1;
			end else begin
				st_dot = 1'b0;
			end
		end
		if (!taken) begin
			if (c.ch == CH_MINUS) begin
				st_minus = 1'b1;
			end else if (c.ch == CH_ZERO && st_width == 0 && !st_minus) begin
				st_zero = 1'b1;
			end else if (c.ch == CH_HASH) begin
				st_hash = 1'b1;
			end else if (c.ch == CH_PLUS) begin
				st_plus = 1'b1;
			end else if (c.ch == CH_SPACE) begin
				st_space = 1'b1;
			end else if (c.ch == CH_DOT) begin
				st_zero = 1'b0;
				st_prec = 0;
				st_dot = 1'b1;
			end else if (digit) begin
				if (st_prec != -1)
					st_prec = times_ten_add(st_prec, d);
				else
					st_width = times_ten_add(st_width, d);
			end else if (c.ch == CH_STAR) begin
				if (st_prec != -1) begin
					st_prec = (arg < 0) ? -1 : arg;
				end else if (arg < 0) begin
					// negative width means left justify
					st_minus = 1'b1;
					st_width = (-arg > SAT_MAX) ? SAT_MAX : -arg;
				end else begin
					st_width = arg;
				end
			end else begin
				r.done = 1'b1;
			end
		end
		r.minus = st_minus;
		r.zero  = st_zero;
		r.hash  = st_hash;
		r.plus  = st_plus;
		r.space = st_space;
		r.width = st_width[30:0];
		r.prec  = st_prec[31:0];
		return r;
	endfunction

	task automatic push_char(input logic s, input logic [7:0] c, input logic signed [31:0] a);
		spec_char_t e;
		e.start = s;
		e.ch = c;
		e.arg = a;
		spec_chars.push_back(e);
	endtask

	function automatic logic signed [31:0] pick_arg();
		case ($urandom_range(0, 7))
			0: return 32'sh0;
			1: return 32'shffff_ffff;
			2: return ARG_MIN;
			3: return 32'sh7fff_ffff;
			4, 5: return 32'($urandom_range(0, 200)) - 32'd100;
			default: return $urandom();
		endcase
	endfunction

	task automatic push_noise();
		push_char(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), pick_arg());
	endtask

	task automatic push_number();
		int n;
		// mostly short numbers, now and then a run long enough to saturate
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 3);
		repeat (n)
			push_char(1'b0, CH_ZERO + 8'($urandom_range(0, 9)), pick_arg());
	endtask

	task automatic push_spec();
		int first;
		first = spec_chars.size();
		repeat ($urandom_range(0, 4)) begin
			case ($urandom_range(0, 4))
				0: push_char(1'b0, CH_MINUS, pick_arg());
				1: push_char(1'b0, CH_ZERO, pick_arg());
				2: push_char(1'b0, CH_HASH, pick_arg());
				3: push_char(1'b0, CH_PLUS, pick_arg());
				default: push_char(1'b0, CH_SPACE, pick_arg());
			endcase
		end
		case ($urandom_range(0, 3))
			0: ;
			1: push_char(1'b0, CH_STAR, pick_arg());
			default: push_number();
		endcase
		if ($urandom_range(0, 1)) begin
			push_char(1'b0, CH_DOT, pick_arg());
			case ($urandom_range(0, 3))
				0: ;
				1: push_char(1'b0, CH_STAR, pick_arg());
				default: push_number();
			endcase
		end
		case ($urandom_range(0, 9))
			0: push_char(1'b0, CH_NUL, pick_arg());
			1: push_noise();
			default: push_char(1'b0, CONV_CHARS[$urandom_range(0, CONV_CHARS.len() - 1)],
				pick_arg());
		endcase
		spec_chars[first].start = ($urandom_range(0, 9) != 0);
		// characters after the end keep updating the state
		if ($urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, 3))
				push_noise();
	endtask

	task automatic check_field(input string name, input logic signed [63:0] want,
		input logic signed [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// driver: presents one character beat at a time, idles in bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			start_req <= 1'b0;
			ch <= '0;
			arg_value <= '0;
			gap_left = 0;
			clear_spec();
		end else begin
			if (in_valid && !in_stall) begin
				flags_due.push_back(parse_char(cur_char));
				if (spec_chars.size() >= 120 && $urandom_range(0, 5) == 0)
					gap_left = $urandom_range(1, 9);
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					in_valid <= 1'b0;
					gap_left--;
				end else if (spec_chars.size() != 0) begin
					cur_char = spec_chars.pop_front();
					in_valid <= 1'b1;
					start_req <= cur_char.start;
					ch <= cur_char.ch;
					arg_value <= cur_char.arg;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result beat against the oldest prediction, stalls in bursts
	always @(posedge clk or negedge arst_n) begin
		flag_state_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (flags_due.size() == 0) begin
					$error("result beat with nothing expected");
					mismatches++;
				end else begin
					want = flags_due.pop_front();
					check_field("done_res", want.done, done_res);
					check_field("left_justify", want.minus, left_justify);
					check_field("zero_pad", want.zero, zero_pad);
					check_field("alt_form", want.hash, alt_form);
					check_field("show_plus", want.plus, show_plus);
					check_field("show_space", want.space, show_space);
					check_field("field_width", want.width, field_width);
					check_field("field_precision", want.prec, field_precision);
				end
			end
			if (stall_left == 0 && spec_chars.size() >= 120 && $urandom_range(0, 7) == 0)
				stall_left = $urandom_range(1, 9);
			if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		// directed: every flag, zero as flag and as digit, dot runs, stars, ends
		push_char(1'b1, CH_ZERO, 32'sh0);
		push_char(1'b0, CH_HASH, 32'sh0);
		push_char(1'b0, CH_PLUS, 32'sh0);
		push_char(1'b0, CH_SPACE, 32'sh0);
		push_char(1'b0, CH_MINUS, 32'sh0);
		push_char(1'b0, CH_ZERO, 32'sh0);
		push_char(1'b0, CH_NINE, 32'sh0);
		push_char(1'b0, CH_ZERO, 32'sh0);
		push_char(1'b0, CH_DOT, 32'sh0);
		push_char(1'b0, CH_ONE, 32'sh0);
		push_char(1'b0, CONV_CHARS[0], 32'sh0);
		push_char(1'b0, CH_NINE, 32'sh0);
		push_char(1'b0, CH_STAR, -32'sd5);
		push_char(1'b0, CH_STAR, ARG_MIN);
		push_char(1'b1, CH_STAR, 32'sh7fff_ffff);
		push_char(1'b0, CH_DOT, 32'sh0);
		push_char(1'b0, CH_STAR, -32'sd1);
		push_char(1'b0, CH_DOT, 32'sh0);
		push_char(1'b0, CH_STAR, 32'sd12345);
		push_char(1'b0, CH_NUL, 32'sh0);
		push_char(1'b1, 8'hff, 32'shffff_ffff);
		push_char(1'b1, CH_DOT, 32'sh0);
		push_char(1'b0, CH_ZERO, 32'sh0);
		push_char(1'b0, CH_STAR, ARG_MIN);
		while (spec_chars.size() < 824) begin
			if ($urandom_range(0, 6) == 0)
				push_noise();
			else
				push_spec();
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (spec_chars.size() != 0 || in_valid)
			@(posedge clk);
		while (flags_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatches == 0 && flags_due.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
